### src/itt_pkg.sv
// ----------------------------------------------------------------------------
// itt_pkg: shared types and constants of the interval timer
// Holds the transfer payloads, the per-channel command and status bundles,
// and the port, operation and access codes.
// ----------------------------------------------------------------------------
package itt_pkg;

  // Largest number of channels the block can be built with.
  localparam int MAX_CHANNELS = 3;

  // Channel whose counting is qualified by the gate port.
  localparam int GATE_CHANNEL = 2;

  // Operation codes.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Port codes.
  localparam logic [2:0] PORT_CONTROL = 3'd3;
  localparam logic [2:0] PORT_GATE    = 3'd4;

  // Access codes of the control byte.
  localparam logic [1:0] ACC_LATCH  = 2'd0;
  localparam logic [1:0] ACC_LOW    = 2'd1;
  localparam logic [1:0] ACC_HIGH   = 2'd2;
  localparam logic [1:0] ACC_LOHI   = 2'd3;

  // Low two bits of the mode code that select the rate generator.
  localparam logic [1:0] MODE_RATE_GEN = 2'b10;

  // Bit of the gate port read that carries the output of the gated channel.
  localparam int GATE_OUT_BIT = 5;

  // Input item.
  typedef struct packed {
    logic [1:0] op;
    logic [2:0] port;
    logic [7:0] write_data;
  } itt_in_t;

  // Result item.
  typedef struct packed {
    logic [7:0] read_data;
    logic [2:0] out_levels;
    logic [2:0] terminal_pulse;
  } itt_out_t;

  // Decoded command for one channel, already qualified by the transfer.
  typedef struct packed {
    logic       tick;
    logic       gate;
    logic       ctrl_wr;
    logic       cnt_wr;
    logic       cnt_rd;
    logic [7:0] data;
  } itt_ch_cmd_t;

  // Status returned by one channel.
  typedef struct packed {
    logic [7:0] rd_data;
    logic       out_cur;
    logic       out_nxt;
    logic       pulse;
  } itt_ch_stat_t;

endpackage

### src/interval_timer_three_channel.sv
// ----------------------------------------------------------------------------
// interval_timer_three_channel: three-channel programmable interval timer
// Byte-port timer with per-channel access and counting modes, a gate port
// and one result per input item.
// ----------------------------------------------------------------------------
// Each input item (a timer tick, a port write or a port read) is taken into
// an input register and from there produces exactly one result in the
// output register: the read byte, the output level of every channel after
// the item, and the terminal-count pulses of a tick. A new item is accepted
// every cycle unless the result side stalls; each item passes the input
// register and the result register around the single pass of channel logic.
// Result-side stalls hold the result register and a full input register.
// ----------------------------------------------------------------------------
module interval_timer_three_channel #(
  parameter int NUM_CHANNELS = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  itt_pkg::itt_in_t in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output itt_pkg::itt_out_t out_item
);

  logic              in_valid_r;
  itt_pkg::itt_in_t  in_item_r;
  logic              out_valid_r;
  itt_pkg::itt_out_t out_r;
  logic [1:0]        gate_r, gate_nxt;

  logic              out_ready;
  logic              advance;
  itt_pkg::itt_out_t result;
  logic [2:0]        lvl_cur;

  itt_pkg::itt_ch_cmd_t  cmd  [NUM_CHANNELS];
  itt_pkg::itt_ch_stat_t stat [NUM_CHANNELS];

  // Pipeline flow control.
  assign out_ready = !out_valid_r || !out_stall;
  assign advance   = in_valid_r && out_ready;
  assign in_stall  = in_valid_r && !out_ready;

  // Per-channel command decode and channel instances.
  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_ch
    assign cmd[i].tick    = advance && (in_item_r.op == itt_pkg::OP_TICK);
    assign cmd[i].gate    = (i == itt_pkg::GATE_CHANNEL) ? gate_r[0] : 1'b1;
    assign cmd[i].ctrl_wr = advance && (in_item_r.op == itt_pkg::OP_WRITE)
                            && (in_item_r.port == itt_pkg::PORT_CONTROL)
                            && (in_item_r.write_data[7:6] == 2'(i));
    assign cmd[i].cnt_wr  = advance && (in_item_r.op == itt_pkg::OP_WRITE)
                            && (in_item_r.port == 3'(i));
    assign cmd[i].cnt_rd  = advance && (in_item_r.op == itt_pkg::OP_READ)
                            && (in_item_r.port == 3'(i));
    assign cmd[i].data    = in_item_r.write_data;

    itt_channel u_ch (
      .clk  (clk),
      .rst_n(rst_n),
      .cmd  (cmd[i]),
      .stat (stat[i])
    );
  end

  // Gate port write.
  always_comb begin
    gate_nxt = gate_r;
    if (advance && (in_item_r.op == itt_pkg::OP_WRITE)
        && (in_item_r.port == itt_pkg::PORT_GATE)) begin
      gate_nxt = in_item_r.write_data[1:0];
    end
  end

  // Result assembly; absent channels read as level high.
  always_comb begin
    lvl_cur               = '1;
    result.read_data      = 8'd0;
    result.out_levels     = '1;
    result.terminal_pulse = 3'd0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      lvl_cur[i]               = stat[i].out_cur;
      result.read_data         = result.read_data | stat[i].rd_data;
      result.out_levels[i]     = stat[i].out_nxt;
      result.terminal_pulse[i] = stat[i].pulse;
    end
    if ((in_item_r.op == itt_pkg::OP_READ) && (in_item_r.port == itt_pkg::PORT_GATE)) begin
      result.read_data[itt_pkg::GATE_OUT_BIT] = lvl_cur[itt_pkg::GATE_CHANNEL];
      result.read_data[1:0]                   = gate_r;
    end
  end

  // Input register, result register and gate bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      gate_r      <= 2'd0;
    end else begin
      if (!in_valid_r || out_ready) begin
        in_valid_r <= in_valid;
      end
      if (out_ready) begin
        out_valid_r <= in_valid_r;
      end
      gate_r <= gate_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_valid_r || out_ready) begin
      in_item_r <= in_item;
    end
    if (advance) begin
      out_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // A stall toward the input is only raised while an item waits.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_valid_r)
    else $error("input stalled with an empty input register");

  // An item that moves on always yields a result.
  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("transfer into result register lost");

  // Only reads return data.
  a_rd_only: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (in_item_r.op != itt_pkg::OP_READ)) |=> (out_r.read_data == 8'd0))
    else $error("read data on a non-read item");

  // Terminal pulses only come from ticks.
  a_pulse_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (in_item_r.op != itt_pkg::OP_TICK)) |=> (out_r.terminal_pulse == 3'd0))
    else $error("terminal pulse on a non-tick item");

endmodule

### src/itt_channel.sv
// ----------------------------------------------------------------------------
// itt_channel: one counter channel of the interval timer
// Holds the count, reload value, latch, byte toggles and output level of a
// channel and applies one decoded command per cycle.
// ----------------------------------------------------------------------------
module itt_channel (
  input  logic                 clk,
  input  logic                 rst_n,
  input  itt_pkg::itt_ch_cmd_t cmd,
  output itt_pkg::itt_ch_stat_t stat
);

  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] reload_r, reload_nxt;
  logic [15:0] latch_r, latch_nxt;
  logic        latch_held_r, latch_held_nxt;
  logic [1:0]  acc_r, acc_nxt;
  logic [2:0]  mode_r, mode_nxt;
  logic        wr_hi_r, wr_hi_nxt;
  logic        rd_hi_r, rd_hi_nxt;
  logic [7:0]  low_hold_r, low_hold_nxt;
  logic        armed_r, armed_nxt;
  logic        out_r, out_nxt;

  logic        rate_gen;
  logic        load_en;
  logic [15:0] load_val;
  logic [15:0] src;
  logic [15:0] cnt_dec;
  logic [7:0]  rd_data;
  logic        pulse;

  assign rate_gen = (mode_r[1:0] == itt_pkg::MODE_RATE_GEN);
  assign src      = latch_held_r ? latch_r : cnt_r;
  assign cnt_dec  = cnt_r - 16'd1;

  // Next state of the channel for the command of this cycle.
  always_comb begin
    cnt_nxt        = cnt_r;
    reload_nxt     = reload_r;
    latch_nxt      = latch_r;
    latch_held_nxt = latch_held_r;
    acc_nxt        = acc_r;
    mode_nxt       = mode_r;
    wr_hi_nxt      = wr_hi_r;
    rd_hi_nxt      = rd_hi_r;
    low_hold_nxt   = low_hold_r;
    armed_nxt      = armed_r;
    out_nxt        = out_r;
    load_en        = 1'b0;
    load_val       = 16'd0;
    rd_data        = 8'd0;
    pulse          = 1'b0;

    if (cmd.ctrl_wr) begin
      if (cmd.data[5:4] == itt_pkg::ACC_LATCH) begin
        if (!latch_held_r) begin
          latch_nxt      = cnt_r;
          latch_held_nxt = 1'b1;
        end
      end else begin
        acc_nxt        = cmd.data[5:4];
        mode_nxt       = cmd.data[3:1];
        wr_hi_nxt      = 1'b0;
        rd_hi_nxt      = 1'b0;
        latch_held_nxt = 1'b0;
        armed_nxt      = 1'b0;
        out_nxt        = (cmd.data[2:1] == itt_pkg::MODE_RATE_GEN);
      end
    end

    // Counter load, one byte per transfer.
    if (cmd.cnt_wr) begin
      case (acc_r)
        itt_pkg::ACC_LOW: begin
          load_en  = 1'b1;
          load_val = {8'd0, cmd.data};
        end
        itt_pkg::ACC_HIGH: begin
          load_en  = 1'b1;
          load_val = {cmd.data, 8'd0};
        end
        itt_pkg::ACC_LOHI: begin
          if (!wr_hi_r) begin
            low_hold_nxt = cmd.data;
            wr_hi_nxt    = 1'b1;
            if (!rate_gen) begin
              armed_nxt = 1'b0;
              out_nxt   = 1'b0;
            end
          end else begin
            wr_hi_nxt = 1'b0;
            load_en   = 1'b1;
            load_val  = {cmd.data, low_hold_r};
          end
        end
        default: ;
      endcase
    end

    if (load_en) begin
      reload_nxt = load_val;
      cnt_nxt    = load_val;
      armed_nxt  = 1'b1;
      out_nxt    = rate_gen;
    end

    // Counter read; the latch is released after its last byte.
    if (cmd.cnt_rd) begin
      case (acc_r)
        itt_pkg::ACC_LOW: begin
          rd_data        = src[7:0];
          latch_held_nxt = 1'b0;
        end
        itt_pkg::ACC_HIGH: begin
          rd_data        = src[15:8];
          latch_held_nxt = 1'b0;
        end
        itt_pkg::ACC_LOHI: begin
          if (!rd_hi_r) begin
            rd_data   = src[7:0];
            rd_hi_nxt = 1'b1;
          end else begin
            rd_data        = src[15:8];
            rd_hi_nxt      = 1'b0;
            latch_held_nxt = 1'b0;
          end
        end
        default: ;
      endcase
    end

    // Timer clock tick.
    if (cmd.tick && armed_r && cmd.gate) begin
      if (rate_gen) begin
        if (cnt_r == 16'd1) begin
          out_nxt = 1'b0;
          cnt_nxt = reload_r;
          pulse   = 1'b1;
        end else begin
          out_nxt = 1'b1;
          cnt_nxt = cnt_dec;
        end
      end else begin
        cnt_nxt = cnt_dec;
        if (cnt_dec == 16'd0 && !out_r) begin
          out_nxt = 1'b1;
          pulse   = 1'b1;
        end
      end
    end
  end

  // Channel state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= 16'd0;
      reload_r     <= 16'd0;
      latch_r      <= 16'd0;
      latch_held_r <= 1'b0;
      acc_r        <= itt_pkg::ACC_LATCH;
      mode_r       <= 3'd0;
      wr_hi_r      <= 1'b0;
      rd_hi_r      <= 1'b0;
      low_hold_r   <= 8'd0;
      armed_r      <= 1'b0;
      out_r        <= 1'b1;
    end else begin
      cnt_r        <= cnt_nxt;
      reload_r     <= reload_nxt;
      latch_r      <= latch_nxt;
      latch_held_r <= latch_held_nxt;
      acc_r        <= acc_nxt;
      mode_r       <= mode_nxt;
      wr_hi_r      <= wr_hi_nxt;
      rd_hi_r      <= rd_hi_nxt;
      low_hold_r   <= low_hold_nxt;
      armed_r      <= armed_nxt;
      out_r        <= out_nxt;
    end
  end

  assign stat.rd_data = rd_data;
  assign stat.out_cur = out_r;
  assign stat.out_nxt = out_nxt;
  assign stat.pulse   = pulse;

endmodule
